[rtl/core/mntt_pkg.sv]
// mntt_pkg: shared constants, types and arithmetic helpers for the ml-kem transform
// used by the controller, datapath and top level; no dependencies
package mntt_pkg;

  localparam int PolyLen       = 256;
  localparam int CoeffsPerItem = 4;
  localparam int ItemsPerPoly  = PolyLen / CoeffsPerItem;
  localparam int AddrW         = $clog2(PolyLen);
  localparam int GroupW        = $clog2(ItemsPerPoly);
  localparam logic signed [15:0] ModQ     = 16'sd3329;
  localparam logic [15:0]        QinvU16  = 16'd62209;
  localparam logic signed [15:0] BarrettV = 16'sd20159;
  localparam logic signed [15:0] InvScale = 16'sd1441;

  typedef enum logic [1:0] {
    OP_FWD   = 2'b00,
    OP_INV   = 2'b01,
    OP_SCALE = 2'b10
  } bf_op_t;

  // controller to datapath
  typedef struct packed {
    logic              rd_en;
    logic [AddrW-1:0]  addr_a;
    logic [AddrW-1:0]  addr_b;
    logic [6:0]        zeta_idx;
    bf_op_t            op;
  } bf_cmd_t;

  // root table, bit-reversed order
  function automatic logic signed [15:0] root_lookup(input logic [6:0] idx);
    logic signed [15:0] tbl [128];
    tbl = '{
      -16'sd1044, -16'sd758, -16'sd359, -16'sd1517, 16'sd1493, 16'sd1422, 16'sd287, 16'sd202,
      16'sd3158, 16'sd622, 16'sd1577, 16'sd182, 16'sd962, 16'sd2127, 16'sd1855, 16'sd1468,
      16'sd573, 16'sd2004, 16'sd264, 16'sd383, 16'sd2500, 16'sd1458, 16'sd1727, 16'sd3199,
      16'sd2648, 16'sd1017, 16'sd732, 16'sd608, 16'sd1787, 16'sd411, 16'sd3124, 16'sd1758,
      16'sd1223, 16'sd652, 16'sd2777, 16'sd1015, 16'sd2036, 16'sd1491, 16'sd3047, 16'sd1785,
      16'sd516, 16'sd3321, 16'sd3009, 16'sd2663, 16'sd1711, 16'sd2167, 16'sd126, 16'sd1469,
      16'sd2476, 16'sd3239, 16'sd3058, 16'sd830, 16'sd107, 16'sd1908, 16'sd3082, 16'sd2378,
      16'sd2931, 16'sd961, 16'sd1821, 16'sd2604, 16'sd448, 16'sd2264, 16'sd677, 16'sd2054,
      16'sd2226, 16'sd430, 16'sd555, 16'sd843, 16'sd2078, 16'sd871, 16'sd1550, 16'sd105,
      16'sd422, 16'sd587, 16'sd177, 16'sd3094, 16'sd3038, 16'sd2869, 16'sd1574, 16'sd1653,
      16'sd3083, 16'sd778, 16'sd1159, 16'sd3182, 16'sd2552, 16'sd1483, 16'sd2727, 16'sd1119,
      16'sd1739, 16'sd644, 16'sd2457, 16'sd349, 16'sd418, 16'sd329, 16'sd3173, 16'sd3254,
      16'sd817, 16'sd1097, 16'sd603, 16'sd610, 16'sd1322, 16'sd2044, 16'sd1864, 16'sd384,
      16'sd2114, 16'sd3193, 16'sd1218, 16'sd1994, 16'sd2455, 16'sd220, 16'sd2142, 16'sd1670,
      16'sd2144, 16'sd1799, 16'sd2051, 16'sd794, 16'sd1819, 16'sd2475, 16'sd2459, 16'sd478,
      16'sd3221, 16'sd3021, 16'sd996, 16'sd991, 16'sd958, 16'sd1869, 16'sd1522, 16'sd1628
    };
    return tbl[idx];
  endfunction

  // montgomery reduction of a product, result wraps to 16 bits
  function automatic logic signed [15:0] mont_red(input logic signed [31:0] a);
    logic [15:0]        t;
    logic signed [31:0] d;
    t = a[15:0] * QinvU16;
    d = a - $signed(t) * ModQ;
    return d[31:16];
  endfunction

  // barrett reduction of a 16-bit value
  function automatic logic signed [15:0] barr_red(input logic signed [15:0] a);
    logic signed [31:0] v;
    logic signed [15:0] t;
    logic signed [31:0] r;
    v = BarrettV * a + 32'sd33554432;
    t = 16'($signed(v[31:26]));
    r = a - t * ModQ;
    return r[15:0];
  endfunction

endpackage

[rtl/core/mntt_ctrl.sv]
// mntt_ctrl: sequencer for load, butterfly layers, scaling and emit
// depends on mntt_pkg
module mntt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      mode,
  input  logic                      in_fire,
  input  logic                      out_free,
  output logic                      in_ready,
  output logic                      load_we,
  output logic [mntt_pkg::GroupW-1:0] load_grp,
  output logic                      emit_rd,
  output logic [mntt_pkg::GroupW-1:0] emit_grp,
  output logic                      emit_last,
  output mntt_pkg::bf_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_BFLY  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [mntt_pkg::GroupW-1:0] cnt_r, cnt_nxt;
  logic [2:0] layer_r, layer_nxt;
  logic [7:0] j_r, j_nxt;
  logic [2:0] drain_r, drain_nxt;
  logic       inv_r, inv_nxt;
  logic       scale_r, scale_nxt;
  logic       emit_wait_r, emit_wait_nxt;

  // j counts butterflies 0..127 per layer; len = 128 >> layer (fwd) or 2 << layer (inv)
  logic [2:0] sh;
  logic [7:0] lenm;
  logic [7:0] a_lo, a_hi;
  logic [7:0] grp;
  logic [6:0] kf, ki;

  always_comb begin
    sh   = inv_r ? (3'd6 - layer_r) : layer_r;
    lenm = 8'd127 >> sh;
    a_lo = j_r & lenm;
    a_hi = (j_r & ~lenm) << 1;
    grp  = j_r >> (3'd7 - sh);
    kf   = 7'((8'd1 << layer_r) + grp);
    ki   = 7'((8'd128 >> layer_r) - 8'd1 - grp);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    layer_nxt     = layer_r;
    j_nxt         = j_r;
    drain_nxt     = drain_r;
    inv_nxt       = inv_r;
    scale_nxt     = scale_r;
    emit_wait_nxt = 1'b0;
    in_ready      = 1'b0;
    load_we       = 1'b0;
    emit_rd       = 1'b0;
    cmd           = '0;
    cmd.op        = mntt_pkg::OP_FWD;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          load_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == mntt_pkg::GroupW'(mntt_pkg::ItemsPerPoly - 1)) begin
            state_nxt = ST_BFLY;
            inv_nxt   = mode;
            layer_nxt = '0;
            j_nxt     = '0;
            scale_nxt = 1'b0;
          end
        end
      end
      ST_BFLY: begin
        cmd.rd_en = 1'b1;
        if (scale_r) begin
          cmd.op     = mntt_pkg::OP_SCALE;
          cmd.addr_a = j_r;
          cmd.addr_b = j_r;
        end else begin
          cmd.op       = inv_r ? mntt_pkg::OP_INV : mntt_pkg::OP_FWD;
          cmd.addr_a   = a_hi | a_lo;
          cmd.addr_b   = (a_hi | a_lo) | (lenm + 8'd1);
          cmd.zeta_idx = inv_r ? ki : kf;
        end
        // one butterfly in flight at a time: read, compute, write back
        state_nxt = ST_DRAIN;
        drain_nxt = 3'd3;
      end
      ST_DRAIN: begin
        drain_nxt = drain_r - 1'b1;
        if (drain_r == 3'd1) begin
          state_nxt = ST_BFLY;
          if (scale_r) begin
            j_nxt = j_r + 1'b1;
            if (j_r == 8'd255) begin
              state_nxt = ST_EMIT;
              cnt_nxt   = '0;
            end
          end else begin
            j_nxt = {1'b0, j_r[6:0] + 7'd1};
            if (j_r[6:0] == 7'd127) begin
              j_nxt     = '0;
              layer_nxt = layer_r + 1'b1;
              if (layer_r == 3'd6) begin
                if (inv_r) begin
                  scale_nxt = 1'b1;
                end else begin
                  state_nxt = ST_EMIT;
                  cnt_nxt   = '0;
                end
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free && !emit_wait_r) begin
          emit_rd       = 1'b1;
          emit_wait_nxt = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == mntt_pkg::GroupW'(mntt_pkg::ItemsPerPoly - 1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign load_grp  = cnt_r;
  assign emit_grp  = cnt_r;
  assign emit_last = (cnt_r == mntt_pkg::GroupW'(mntt_pkg::ItemsPerPoly - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      layer_r     <= '0;
      j_r         <= '0;
      drain_r     <= '0;
      inv_r       <= 1'b0;
      scale_r     <= 1'b0;
      emit_wait_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      layer_r     <= layer_nxt;
      j_r         <= j_nxt;
      drain_r     <= drain_nxt;
      inv_r       <= inv_nxt;
      scale_r     <= scale_nxt;
      emit_wait_r <= emit_wait_nxt;
    end
  end

endmodule

[rtl/core/mntt_dp.sv]
// mntt_dp: coefficient store (four banks by low address bits) and butterfly unit
// depends on mntt_pkg
module mntt_dp (
  input  logic                        clk,
  input  logic                        load_we,
  input  logic [mntt_pkg::GroupW-1:0] load_grp,
  input  logic signed [15:0]          ld_0,
  input  logic signed [15:0]          ld_1,
  input  logic signed [15:0]          ld_2,
  input  logic signed [15:0]          ld_3,
  input  logic                        emit_rd,
  input  logic [mntt_pkg::GroupW-1:0] emit_grp,
  input  mntt_pkg::bf_cmd_t           cmd,
  output logic signed [15:0]          rd_0,
  output logic signed [15:0]          rd_1,
  output logic signed [15:0]          rd_2,
  output logic signed [15:0]          rd_3
);

  logic signed [15:0] bank0 [mntt_pkg::ItemsPerPoly];
  logic signed [15:0] bank1 [mntt_pkg::ItemsPerPoly];
  logic signed [15:0] bank2 [mntt_pkg::ItemsPerPoly];
  logic signed [15:0] bank3 [mntt_pkg::ItemsPerPoly];

  // stage 1: read operands
  logic signed [15:0] a_r, b_r, z_r;
  logic [mntt_pkg::AddrW-1:0] aa_r, ab_r;
  mntt_pkg::bf_op_t op_r;
  logic v1_r;
  // stage 2: product registered
  logic signed [31:0] p_r;
  logic signed [15:0] a2_r, sum_r;
  logic [mntt_pkg::AddrW-1:0] aa2_r, ab2_r;
  mntt_pkg::bf_op_t op2_r;
  logic v2_r;

  function automatic logic signed [15:0] bank_rd(input logic [mntt_pkg::AddrW-1:0] ad,
      input logic signed [15:0] x0, input logic signed [15:0] x1,
      input logic signed [15:0] x2, input logic signed [15:0] x3);
    logic signed [15:0] r;
    case (ad[1:0])
      2'd0: r = x0;
      2'd1: r = x1;
      2'd2: r = x2;
      default: r = x3;
    endcase
    return r;
  endfunction

  logic signed [15:0] diff_w;
  logic signed [15:0] mr_w, hi_w, lo_w;
  logic [mntt_pkg::GroupW-1:0] ra, rb;

  // emit reads share the first operand port
  assign ra = emit_rd ? emit_grp : cmd.addr_a[mntt_pkg::AddrW-1:2];
  assign rb = cmd.addr_b[mntt_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    v1_r <= cmd.rd_en;
    if (cmd.rd_en) begin
      a_r <= bank_rd(cmd.addr_a, bank0[ra], bank1[ra], bank2[ra], bank3[ra]);
      b_r <= bank_rd(cmd.addr_b, bank0[rb], bank1[rb], bank2[rb], bank3[rb]);
      z_r <= (cmd.op == mntt_pkg::OP_SCALE) ? mntt_pkg::InvScale
                                            : mntt_pkg::root_lookup(cmd.zeta_idx);
      aa_r <= cmd.addr_a;
      ab_r <= cmd.addr_b;
      op_r <= cmd.op;
    end
    if (emit_rd) begin
      rd_0 <= bank0[ra];
      rd_1 <= bank1[ra];
      rd_2 <= bank2[ra];
      rd_3 <= bank3[ra];
    end
  end

  always_comb begin
    diff_w = b_r - a_r;
  end

  always_ff @(posedge clk) begin
    v2_r  <= v1_r;
    a2_r  <= a_r;
    sum_r <= a_r + b_r;
    aa2_r <= aa_r;
    ab2_r <= ab_r;
    op2_r <= op_r;
    case (op_r)
      mntt_pkg::OP_INV: p_r <= z_r * diff_w;
      default:          p_r <= z_r * b_r;
    endcase
  end

  always_comb begin
    mr_w = mntt_pkg::mont_red(p_r);
    case (op2_r)
      mntt_pkg::OP_FWD: begin
        lo_w = a2_r + mr_w;
        hi_w = a2_r - mr_w;
      end
      mntt_pkg::OP_INV: begin
        lo_w = mntt_pkg::barr_red(sum_r);
        hi_w = mr_w;
      end
      default: begin
        lo_w = mr_w;
        hi_w = mr_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      bank0[load_grp] <= ld_0;
      bank1[load_grp] <= ld_1;
      bank2[load_grp] <= ld_2;
      bank3[load_grp] <= ld_3;
    end else if (v2_r) begin
      // scaling writes one entry only
      case (ab2_r[1:0])
        2'd0: bank0[ab2_r[mntt_pkg::AddrW-1:2]] <= hi_w;
        2'd1: bank1[ab2_r[mntt_pkg::AddrW-1:2]] <= hi_w;
        2'd2: bank2[ab2_r[mntt_pkg::AddrW-1:2]] <= hi_w;
        default: bank3[ab2_r[mntt_pkg::AddrW-1:2]] <= hi_w;
      endcase
      if (aa2_r[1:0] != ab2_r[1:0]) begin
        case (aa2_r[1:0])
          2'd0: bank0[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          2'd1: bank1[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          2'd2: bank2[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          default: bank3[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
        endcase
      end else if (aa2_r != ab2_r) begin
        // same bank, different row: every layer with len of 4 or more
        case (aa2_r[1:0])
          2'd0: bank0[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          2'd1: bank1[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          2'd2: bank2[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
          default: bank3[aa2_r[mntt_pkg::AddrW-1:2]] <= lo_w;
        endcase
      end
    end
  end

endmodule

[rtl/core/modq_ntt_forward_inverse.sv]
// modq_ntt_forward_inverse: ml-kem forward/inverse transform, top level
// instantiates mntt_ctrl and mntt_dp; uses mntt_pkg
//
// usage: write cfg_transform_mode (0 forward, 1 inverse with scaling) while idle.
// send 64 input items of four coefficients, lowest index first; the mode held
// when the 64th item is taken applies. the block then runs 896 butterflies
// (plus 256 scaling steps in inverse mode) on one shared butterfly unit, each
// in turn: read, multiply, reduce, write back through the store.
// it then emits 64 result items, last_group high on the final one.
// input items are taken only while loading. an output register holds each result
// item; while out_stall is high it holds and the emit pauses. reset clears the
// controller and mode; the store is not cleared and every entry is written
// before it is read.
module modq_ntt_forward_inverse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_transform_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_coef_in_0,
  input  logic signed [15:0] in_coef_in_1,
  input  logic signed [15:0] in_coef_in_2,
  input  logic signed [15:0] in_coef_in_3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_coef_out_0,
  output logic signed [15:0] out_coef_out_1,
  output logic signed [15:0] out_coef_out_2,
  output logic signed [15:0] out_coef_out_3,
  output logic               out_last_group
);

  logic mode_r;
  logic in_ready, in_fire, load_we, emit_rd, emit_last;
  logic [mntt_pkg::GroupW-1:0] load_grp, emit_grp;
  mntt_pkg::bf_cmd_t cmd;
  logic rd_pend_r, last_pend_r;
  logic out_free;
  logic signed [15:0] rd_0, rd_1, rd_2, rd_3;

  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;
  // emit only when output register is empty or draining, and no read is pending
  assign out_free = (!out_valid || !out_stall) && !rd_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      out_valid   <= 1'b0;
      rd_pend_r   <= 1'b0;
      last_pend_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_transform_mode;
      rd_pend_r <= emit_rd;
      if (emit_rd) last_pend_r <= emit_last;
      if (rd_pend_r) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_coef_out_0 <= rd_0;
      out_coef_out_1 <= rd_1;
      out_coef_out_2 <= rd_2;
      out_coef_out_3 <= rd_3;
      out_last_group <= last_pend_r;
    end
  end

  mntt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_fire   (in_fire),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .load_we   (load_we),
    .load_grp  (load_grp),
    .emit_rd   (emit_rd),
    .emit_grp  (emit_grp),
    .emit_last (emit_last),
    .cmd       (cmd)
  );

  mntt_dp u_dp (
    .clk      (clk),
    .load_we  (load_we),
    .load_grp (load_grp),
    .ld_0     (in_coef_in_0),
    .ld_1     (in_coef_in_1),
    .ld_2     (in_coef_in_2),
    .ld_3     (in_coef_in_3),
    .emit_rd  (emit_rd),
    .emit_grp (emit_grp),
    .cmd      (cmd),
    .rd_0     (rd_0),
    .rd_1     (rd_1),
    .rd_2     (rd_2),
    .rd_3     (rd_3)
  );

endmodule
